FILE: design/mhs_pkg.sv
`default_nettype none
package mhs_pkg;
	localparam int MAX_NGRAM  = 16;
	localparam int MAX_HASHES = 64;
	localparam int SEED_W     = 6;
	localparam int NG_W       = 5;
	localparam int BK_W       = 7;

	localparam logic [1:0] REG_NGRAM  = 2'd0;
	localparam logic [1:0] REG_BCOUNT = 2'd1;
	localparam logic [1:0] REG_BSIZE  = 2'd2;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction

	typedef struct packed {
		logic        start;
		logic [31:0] h;
		logic [31:0] w;
		logic        mix;
		logic        body;
	} hstep_t;
endpackage
`default_nettype wire

FILE: design/mhs_hash.sv
`default_nettype none
// one murmur3 round engine: one block per call, with the finalizer when fin is set
module mhs_hash
	import mhs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hstep_t      req,
	input  wire logic        fin,
	input  wire logic [4:0]  len,
	output logic             done,
	output logic [31:0]      hout
);
	typedef enum logic [3:0] {
		H_IDLE, H_M1, H_M2, H_M3, H_B1, H_F0, H_F1, H_F2, H_F3, H_F4
	} hst_t;
	hst_t st_q;
	logic [31:0] h_q, k_q;
	logic        body_q, fin_q;
	logic [4:0]  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				H_IDLE: if (req.start) begin
					h_q <= req.h; k_q <= req.w; body_q <= req.body;
					fin_q <= fin; len_q <= len;
					st_q <= req.mix ? H_M1 : (fin ? H_F0 : H_IDLE);
					if (!req.mix && !fin) begin hout <= req.h; done <= 1'b1; end
				end
				H_M1: begin k_q <= k_q * C1; st_q <= H_M2; end
				H_M2: begin k_q <= rotl(k_q, 15); st_q <= H_M3; end
				H_M3: begin k_q <= k_q * C2; st_q <= H_B1; end
				H_B1: begin
					if (body_q) h_q <= rotl(h_q ^ k_q, 13) * 32'd5 + 32'he6546b64;
					else h_q <= h_q ^ k_q;
					if (fin_q) st_q <= H_F0;
					else begin
						st_q <= H_IDLE; done <= 1'b1;
						hout <= body_q ? rotl(h_q ^ k_q, 13) * 32'd5 + 32'he6546b64
							: h_q ^ k_q;
					end
				end
				H_F0: begin
					h_q <= (h_q ^ {27'd0, len_q}) ^ ((h_q ^ {27'd0, len_q}) >> 16);
					st_q <= H_F1;
				end
				H_F1: begin h_q <= h_q * F1; st_q <= H_F2; end
				H_F2: begin h_q <= (h_q ^ (h_q >> 13)) * F2; st_q <= H_F3; end
				H_F3: begin
					hout <= h_q ^ (h_q >> 16); done <= 1'b1; st_q <= H_IDLE;
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/minhash_ngram_signature.sv
`default_nettype none
// minhash n-gram signature
// s_axis: one request per text byte; tdata = {text_end, has_byte, data_byte}.
// m_axis: one result per seed on text end, last_value on tlast.
// cfg: write channel, index 0 ngram_len, 1 bucket_count, 2 slots per bucket.
// each byte with a full window runs murmur3 for every seed through one
// shared round engine; a seed runs its blocks in order, the last with the
// finalizer, then a read and an update of the minimum, and the next byte
// is taken only after the last seed. minima live in a 64-entry memory whose
// registered read comes in the cycle before its write. on text end each
// seed is read out and written back to all ones; a stalled receiver holds
// the output register and the readout waits. after the last result the
// entries above the last seed are swept to all ones, one per cycle, before
// s_axis_tready returns. reset clears registers only; all 64 entries of the
// minima memory are swept to all ones after reset before s_axis_tready goes
// high. config is taken at any time but meant only while idle.
module minhash_ngram_signature
	import mhs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // data_byte, has_byte, text_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // bucket_index, slot_index, min_value
	output logic             m_axis_tlast,  // last_value
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SEED, S_BLK, S_WAIT, S_RD, S_UPD, S_ORD, S_OUT
	} st_t;
	st_t st_q;

	logic [NG_W-1:0] ngram_q;
	logic [BK_W-1:0] bcnt_q, bsize_q;
	logic [7:0]      win_q [MAX_NGRAM];
	logic [4:0]      fill_q;
	logic [31:0]     mem [MAX_HASHES];
	logic [31:0]     rd_s1;
	logic [SEED_W:0] seed_q;
	logic [2:0]      blk_q;
	logic [31:0]     h_q;
	logic            end_q;
	logic [5:0]      bkt_q, slt_q;

	logic [4:0] n_eff;
	logic [6:0] bs_eff, bc_eff, hc_eff;
	logic [13:0] prod;
	assign n_eff  = (ngram_q == 5'd0) ? 5'd1 : ((ngram_q > 5'd16) ? 5'd16 : ngram_q);
	assign bs_eff = (bsize_q == 7'd0) ? 7'd1 : ((bsize_q > 7'd64) ? 7'd64 : bsize_q);
	assign bc_eff = (bcnt_q == 7'd0) ? 7'd1 : ((bcnt_q > 7'd64) ? 7'd64 : bcnt_q);
	assign prod   = 14'(bc_eff) * 14'(bs_eff);
	assign hc_eff = (prod > 14'd64) ? 7'd64 : prod[6:0];

	// assemble block blk_q of the ngram (oldest byte first)
	logic [2:0] nblk;
	logic [1:0] rem;
	logic [31:0] wrd;
	logic [4:0] base;
	assign nblk = n_eff[4:2];
	assign rem  = n_eff[1:0];
	assign base = 5'd16 - n_eff + {1'b0, blk_q[1:0], 2'b00};
	always_comb begin
		logic [4:0] ix;
		wrd = '0;
		for (int b = 0; b < 4; b++) begin
			ix = base + 5'(b);
			if ((blk_q < nblk) || (5'(b) < {3'd0, rem}))
				wrd[8*b +: 8] = win_q[ix[3:0]];
		end
	end

	hstep_t hreq;
	logic hdone;
	logic [31:0] hout;
	logic hfin;
	logic last_blk;
	assign last_blk = (rem == 2'd0) ? (blk_q == nblk - 3'd1) : (blk_q == nblk);
	assign hfin = last_blk;
	always_comb begin
		hreq.start = (st_q == S_BLK);
		hreq.h     = (blk_q == 3'd0) ? {26'd0, seed_q[5:0]} : h_q;
		hreq.w     = wrd;
		hreq.mix   = 1'b1;
		hreq.body  = (blk_q < nblk);
	end

	mhs_hash u_hash (
		.clk(clk), .arst_n(arst_n), .req(hreq), .fin(hfin), .len(n_eff),
		.done(hdone), .hout(hout)
	);

	assign s_axis_tready = (st_q == S_IDLE);
	assign cfg_ready     = 1'b1;

	logic hout_q_lt;
	assign hout_q_lt = h_q < rd_s1;

	// read data is held while a result waits to be sent
	always_ff @(posedge clk) begin
		if (st_q == S_CLR) mem[seed_q[5:0]] <= 32'hffffffff;
		else if (st_q == S_UPD && hout_q_lt) mem[seed_q[5:0]] <= h_q;
		else if (st_q == S_ORD) mem[seed_q[5:0]] <= 32'hffffffff;
		if (st_q != S_OUT) rd_s1 <= mem[seed_q[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; seed_q <= '0; blk_q <= '0; fill_q <= '0;
			ngram_q <= 5'd5; bcnt_q <= 7'd8; bsize_q <= 7'd8;
			m_axis_tvalid <= 1'b0; end_q <= 1'b0;
			for (int i = 0; i < MAX_NGRAM; i++) win_q[i] <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_NGRAM:  ngram_q <= cfg_data[4:0];
					REG_BCOUNT: bcnt_q <= cfg_data;
					REG_BSIZE:  bsize_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready && st_q != S_OUT) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					if (seed_q == 7'(MAX_HASHES - 1)) begin
						seed_q <= '0; st_q <= S_IDLE;
					end else seed_q <= seed_q + 7'd1;
				end
				S_IDLE: if (s_axis_tvalid) begin
					end_q <= s_axis_tdata[9];
					seed_q <= '0; blk_q <= '0; bkt_q <= '0; slt_q <= '0;
					if (s_axis_tdata[8]) begin
						for (int i = 0; i < MAX_NGRAM - 1; i++) win_q[i] <= win_q[i+1];
						win_q[MAX_NGRAM-1] <= s_axis_tdata[7:0];
						if (fill_q < 5'd16) fill_q <= fill_q + 5'd1;
						if (((fill_q < 5'd16) ? fill_q + 5'd1 : fill_q) >= n_eff)
							st_q <= S_BLK;
						else if (s_axis_tdata[9]) st_q <= S_ORD;
					end else if (s_axis_tdata[9]) st_q <= S_ORD;
				end
				S_BLK: st_q <= S_WAIT;
				S_WAIT: if (hdone) begin
					h_q <= hout;
					if (last_blk) st_q <= S_RD;
					else begin blk_q <= blk_q + 3'd1; st_q <= S_BLK; end
				end
				S_RD: st_q <= S_UPD;
				S_UPD: begin
					blk_q <= '0;
					if (seed_q + 7'd1 == hc_eff) begin
						seed_q <= '0;
						st_q <= end_q ? S_ORD : S_IDLE;
					end else begin
						seed_q <= seed_q + 7'd1; st_q <= S_BLK;
					end
				end
				S_ORD: st_q <= S_OUT;
				S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata <= {4'd0, rd_s1[15:0], slt_q, bkt_q};
					m_axis_tlast <= (seed_q + 7'd1 == hc_eff);
					if ({1'b0, slt_q} + 7'd1 == bs_eff) begin
						slt_q <= '0; bkt_q <= bkt_q + 6'd1;
					end else slt_q <= slt_q + 6'd1;
					if (seed_q + 7'd1 == hc_eff) begin
						fill_q <= '0;
						for (int i = 0; i < MAX_NGRAM; i++) win_q[i] <= '0;
						// minima above the last seed go back to all ones too
						if (seed_q == 7'(MAX_HASHES - 1)) begin
							seed_q <= '0; st_q <= S_IDLE;
						end else begin
							seed_q <= seed_q + 7'd1; st_q <= S_CLR;
						end
					end else begin
						seed_q <= seed_q + 7'd1; st_q <= S_ORD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/mhs_checker.sv
`default_nettype none
module mhs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result changed under stall");
	// no input taken while a result other than the last is pending output
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input accepted during readout");
	// padding above min_value stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
		else $error("padding bits set");
endmodule
bind minhash_ngram_signature mhs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
